@@ src/path_safety_checker_core_macros.svh @@
// Assertion macros for the path safety checker.
`ifndef PATH_SAFETY_CHECKER_CORE_MACROS_SVH
`define PATH_SAFETY_CHECKER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define PSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("psc: same-cycle implication failed");

`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("psc: next-cycle implication failed");

`else

`define PSC_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define PSC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/psc_pkg.sv @@
package psc_pkg;

	localparam int LengthBits = 17;
	localparam int CmpBits = (LengthBits > 16) ? LengthBits : 16;
	localparam int QueueDepth = 4;
	localparam int QPtrBits = $clog2(QueueDepth);

	localparam logic [15:0] MaxLengthReset = 16'd4096;

	localparam logic [7:0] ChNull = 8'h00;
	localparam logic [7:0] ChTab = 8'h09;
	localparam logic [7:0] ChNewline = 8'h0A;
	localparam logic [7:0] ChSpace = 8'h20;
	localparam logic [7:0] ChDot = 8'h2E;
	localparam logic [7:0] ChSlash = 8'h2F;
	localparam logic [7:0] ChBackslash = 8'h5C;
	localparam logic [7:0] ChTilde = 8'h7E;
	localparam logic [7:0] ChOne = 8'h31;
	localparam logic [7:0] ChNine = 8'h39;

	localparam logic [23:0] NameCon = "CON";
	localparam logic [23:0] NamePrn = "PRN";
	localparam logic [23:0] NameAux = "AUX";
	localparam logic [23:0] NameNul = "NUL";
	localparam logic [23:0] NameCom = "COM";
	localparam logic [23:0] NameLpt = "LPT";

	localparam logic [2:0] CompKeep = 3'd4;
	localparam logic [2:0] CompSat = 3'd5;

	localparam int FlagNull = 0;
	localparam int FlagCtrl = 1;
	localparam int FlagTrav = 2;
	localparam int FlagRsvd = 3;

	localparam logic [2:0] VerdictSafe = 3'd0;
	localparam logic [2:0] VerdictEmpty = 3'd1;
	localparam logic [2:0] VerdictTooLong = 3'd2;
	localparam logic [2:0] VerdictNull = 3'd3;
	localparam logic [2:0] VerdictCtrl = 3'd4;
	localparam logic [2:0] VerdictTrav = 3'd5;
	localparam logic [2:0] VerdictRsvd = 3'd6;

	typedef struct packed {
		logic [7:0] ch;
		logic       has_char;
		logic       is_last;
		logic       is_null;
		logic       is_ctrl;
	} psc_item_t;

	typedef struct packed {
		logic empty;
		logic full;
	} psc_qstat_t;

	typedef logic [3:0][7:0] psc_comp_t;

	function automatic logic component_reserved(input logic [2:0] len, input psc_comp_t b);
		logic [23:0] head;
		logic        res;
		head = {b[0], b[1], b[2]};
		case (len)
			3'd1: res = (b[0] == ChDot) || (b[0] == ChTilde);
			3'd2: res = (b[0] == ChDot) && (b[1] == ChDot);
			3'd3: res = (head == NameCon) || (head == NamePrn) ||
				(head == NameAux) || (head == NameNul);
			3'd4: res = ((head == NameCom) || (head == NameLpt)) &&
				(b[3] >= ChOne) && (b[3] <= ChNine);
			default: res = 1'b0;
		endcase
		return res;
	endfunction

endpackage

@@ src/psc_in_if.sv @@
interface psc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       has_char;
	logic       is_last;

	modport source (output valid, output ch, output has_char, output is_last, input ready);
	modport sink (input valid, input ch, input has_char, input is_last, output ready);
endinterface

@@ src/psc_out_if.sv @@
interface psc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] verdict;

	modport source (output valid, output verdict, input ready);
	modport sink (input valid, input verdict, output ready);
endinterface

@@ src/psc_front.sv @@
module psc_front (
	psc_in_if.sink          path_in,
	input  psc_pkg::psc_qstat_t q_status,
	output logic            push,
	output psc_pkg::psc_item_t push_item
);

	assign path_in.ready = !q_status.full;

	// An item with no byte that does not end a path changes nothing, so it is dropped here.
	assign push = path_in.valid && path_in.ready && (path_in.has_char || path_in.is_last);

	always_comb begin
		push_item.ch = path_in.ch;
		push_item.has_char = path_in.has_char;
		push_item.is_last = path_in.is_last;
		push_item.is_null = (path_in.ch == psc_pkg::ChNull);
		push_item.is_ctrl = (path_in.ch != psc_pkg::ChNull) && (path_in.ch < psc_pkg::ChSpace) &&
			(path_in.ch != psc_pkg::ChTab) && (path_in.ch != psc_pkg::ChNewline);
	end

endmodule

@@ src/psc_queue.sv @@
module psc_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  psc_pkg::psc_item_t push_item,
	input  logic               pop,
	output psc_pkg::psc_item_t head,
	output psc_pkg::psc_qstat_t status
);

	psc_pkg::psc_item_t entries_q [psc_pkg::QueueDepth];
	logic [psc_pkg::QPtrBits-1:0] wr_ptr_q;
	logic [psc_pkg::QPtrBits-1:0] rd_ptr_q;
	logic [psc_pkg::QPtrBits:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	assign head = entries_q[rd_ptr_q];
	assign status.empty = (count_q == '0);
	assign status.full = (count_q == (psc_pkg::QPtrBits+1)'(psc_pkg::QueueDepth));

endmodule

@@ src/psc_back.sv @@
module psc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         max_length,
	input  psc_pkg::psc_qstat_t q_status,
	input  psc_pkg::psc_item_t  head,
	output logic                pop,
	psc_out_if.source           verdict_out
);

	localparam logic [psc_pkg::LengthBits-1:0] CountMax = '1;

	logic [psc_pkg::LengthBits-1:0] count_q, nc_count;
	logic [7:0]                     prev0_q, prev1_q, np0, np1;
	logic [2:0]                     len_q, nlen;
	psc_pkg::psc_comp_t             bytes_q, nb;
	logic [3:0]                     flags_q, nf, fin_flags;
	logic [2:0]                     verdict;
	logic                           out_valid_q;
	logic [2:0]                     verdict_q;

	always_comb begin
		nc_count = count_q;
		np0 = prev0_q;
		np1 = prev1_q;
		nlen = len_q;
		nb = bytes_q;
		nf = flags_q;
		if (head.has_char) begin
			if (head.is_null) begin
				nf[psc_pkg::FlagNull] = 1'b1;
			end
			if (head.is_ctrl) begin
				nf[psc_pkg::FlagCtrl] = 1'b1;
			end
			if ((count_q >= psc_pkg::LengthBits'(2)) && (prev1_q == psc_pkg::ChDot) &&
				(prev0_q == psc_pkg::ChDot) &&
				((head.ch == psc_pkg::ChSlash) || (head.ch == psc_pkg::ChBackslash))) begin
				nf[psc_pkg::FlagTrav] = 1'b1;
			end
			if ((count_q == psc_pkg::LengthBits'(1)) && (prev0_q == psc_pkg::ChDot) &&
				(head.ch == psc_pkg::ChDot)) begin
				nf[psc_pkg::FlagTrav] = 1'b1;
			end
			if (head.ch == psc_pkg::ChSlash) begin
				if (psc_pkg::component_reserved(len_q, bytes_q)) begin
					nf[psc_pkg::FlagRsvd] = 1'b1;
				end
				nlen = '0;
			end else begin
				if (len_q < psc_pkg::CompKeep) begin
					nb[len_q[1:0]] = head.ch;
				end
				if (len_q < psc_pkg::CompSat) begin
					nlen = len_q + 1'b1;
				end
			end
			np1 = prev0_q;
			np0 = head.ch;
			if (count_q != CountMax) begin
				nc_count = count_q + 1'b1;
			end
		end
	end

	always_comb begin
		fin_flags = nf;
		if (psc_pkg::component_reserved(nlen, nb)) begin
			fin_flags[psc_pkg::FlagRsvd] = 1'b1;
		end
		if (nc_count == '0) begin
			verdict = psc_pkg::VerdictEmpty;
		end else if (psc_pkg::CmpBits'(nc_count) > psc_pkg::CmpBits'(max_length)) begin
			verdict = psc_pkg::VerdictTooLong;
		end else if (fin_flags[psc_pkg::FlagNull]) begin
			verdict = psc_pkg::VerdictNull;
		end else if (fin_flags[psc_pkg::FlagCtrl]) begin
			verdict = psc_pkg::VerdictCtrl;
		end else if (fin_flags[psc_pkg::FlagTrav]) begin
			verdict = psc_pkg::VerdictTrav;
		end else if (fin_flags[psc_pkg::FlagRsvd]) begin
			verdict = psc_pkg::VerdictRsvd;
		end else begin
			verdict = psc_pkg::VerdictSafe;
		end
	end

	assign pop = !q_status.empty && (!head.is_last || !out_valid_q || verdict_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			prev0_q <= '0;
			prev1_q <= '0;
			len_q <= '0;
			bytes_q <= '0;
			flags_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head.is_last) begin
					count_q <= '0;
					prev0_q <= '0;
					prev1_q <= '0;
					len_q <= '0;
					bytes_q <= '0;
					flags_q <= '0;
				end else begin
					count_q <= nc_count;
					prev0_q <= np0;
					prev1_q <= np1;
					len_q <= nlen;
					bytes_q <= nb;
					flags_q <= nf;
				end
			end
			if (pop && head.is_last) begin
				out_valid_q <= 1'b1;
			end else if (verdict_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head.is_last) begin
			verdict_q <= verdict;
		end
	end

	assign verdict_out.valid = out_valid_q;
	assign verdict_out.verdict = verdict_q;

endmodule

@@ src/path_safety_checker_core.sv @@
// Streaming path checker: one path byte is accepted per clock cycle while the queue is not full,
// and the item marked last yields one verdict. That item is written into the queue, read out by
// the back, and its verdict is registered in the output register. The front classifies each byte
// and writes it into a four-entry queue. The back reads one queued item per cycle and updates the
// per-path state, so the rate is set by that single read port. The back stalls only when the item
// at the head of the queue ends a path and the previous verdict is still waiting, untaken, in the
// output register.
`include "path_safety_checker_core_macros.svh"

module path_safety_checker_core (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cfg_we,
	input  logic [15:0] cfg_wdata,
	psc_in_if.sink    path_in,
	psc_out_if.source verdict_out
);

	logic [15:0]         max_length_q;
	logic                q_push;
	logic                q_pop;
	psc_pkg::psc_item_t  q_push_item;
	psc_pkg::psc_item_t  q_head;
	psc_pkg::psc_qstat_t q_status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= psc_pkg::MaxLengthReset;
		end else if (cfg_we) begin
			max_length_q <= cfg_wdata;
		end
	end

	psc_front u_front (
		.path_in   (path_in),
		.q_status  (q_status),
		.push      (q_push),
		.push_item (q_push_item)
	);

	psc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.pop       (q_pop),
		.head      (q_head),
		.status    (q_status)
	);

	psc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.max_length  (max_length_q),
		.q_status    (q_status),
		.head        (q_head),
		.pop         (q_pop),
		.verdict_out (verdict_out)
	);

	`PSC_ASSERT_NEXT(a_idle_queue_stays_empty, clk, arst_n, q_status.empty && !q_push, q_status.empty)
	`PSC_ASSERT_NEXT(a_last_pop_gives_verdict, clk, arst_n, q_pop && q_head.is_last, verdict_out.valid)
	`PSC_ASSERT_IMPLIES(a_no_overwrite, clk, arst_n, verdict_out.valid && !verdict_out.ready, !(q_pop && q_head.is_last))

endmodule
